// ===== rtl/hermite_ephemeris_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ephemeris table
// Shared property forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef HERMITE_EPHEMERIS_TABLE_ASSERT_SVH
`define HERMITE_EPHEMERIS_TABLE_ASSERT_SVH

// same-cycle implication
`define HEPH_ASSERT_IMP(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define HEPH_ASSERT_NXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/heph_pkg.sv =====
// ----------------------------------------------------------------------------
// heph_pkg
// Types, codes and helpers shared by the ephemeris table modules
// ----------------------------------------------------------------------------
package heph_pkg;

	localparam int VAL_W    = 48;
	localparam int MAX_COMP = 3;
	localparam int OP_W     = 49;
	localparam int ACC_W    = 128;
	localparam int H_W      = 36;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_QUERY  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		kind_t                          kind;
		logic [VAL_W-1:0]               epoch;
		logic [MAX_COMP-1:0][VAL_W-1:0] pos;
		logic [MAX_COMP-1:0][VAL_W-1:0] rate;
	} req_t;

	typedef struct packed {
		status_t                        status;
		logic [MAX_COMP-1:0][VAL_W-1:0] vals;
	} res_t;

	typedef struct packed {
		logic                   start;
		logic                   clr;
		logic                   shl;
		logic signed [OP_W-1:0] a;
		logic signed [OP_W-1:0] b;
	} mac_cmd_t;

	// arithmetic shift right by 32, then saturate to 48 bits
	function automatic logic [VAL_W-1:0] sat48(input logic [ACC_W-1:0] acc);
		logic [ACC_W-33:0] x;
		x = acc[ACC_W-1:32];
		if ((&x[ACC_W-33:VAL_W-1]) || !(|x[ACC_W-33:VAL_W-1]))
			return x[VAL_W-1:0];
		else if (x[ACC_W-33])
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

endpackage

// ===== rtl/heph_ram.sv =====
// ----------------------------------------------------------------------------
// heph_ram
// Generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module heph_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/heph_front.sv =====
// ----------------------------------------------------------------------------
// heph_front
// Accepts input items, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`include "hermite_ephemeris_table_assert.svh"

module heph_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [335:0]    s_tdata,   // epoch, pos_x, pos_y, pos_z, rate_x, rate_y, rate_z
	input  logic [0:0]      s_tuser,   // req_type
	output logic            req_valid,
	output heph_pkg::req_t  req,
	input  logic            req_pop
);
	import heph_pkg::*;

	req_t       fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	req_t       item;
	logic       push;

	// unpack and classify the incoming item
	always_comb begin
		item.kind  = kind_t'(s_tuser[0]);
		item.epoch = s_tdata[VAL_W-1:0];
		for (int c = 0; c < MAX_COMP; c++) begin
			item.pos[c]  = s_tdata[VAL_W*(1+c) +: VAL_W];
			item.rate[c] = s_tdata[VAL_W*(1+MAX_COMP+c) +: VAL_W];
		end
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = fifo_q[rd_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= item;
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (req_pop)
				rd_q <= ~rd_q;
			if (push && !req_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (req_pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	`HEPH_ASSERT_IMP(a_fill_bound, 1'b1, cnt_q <= 2'd2, "queue fill above depth")
	`HEPH_ASSERT_IMP(a_pop_nonempty, req_pop, cnt_q != 2'd0, "pop from empty queue")
	`HEPH_ASSERT_IMP(a_ptr_fill, wr_q != rd_q, cnt_q == 2'd1, "pointers disagree with fill")
	`HEPH_ASSERT_NXT(a_drain, req_pop && !push && cnt_q == 2'd1, cnt_q == 2'd0,
		"queue did not drain")

endmodule

// ===== rtl/heph_mac.sv =====
// ----------------------------------------------------------------------------
// heph_mac
// Multi-cycle signed multiply-accumulate, 17 bits of one operand per cycle
// ----------------------------------------------------------------------------
module heph_mac #(
	parameter int DER_SHIFT = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  heph_pkg::mac_cmd_t         cmd,
	output logic                       done,
	output logic [heph_pkg::ACC_W-1:0] acc
);
	import heph_pkg::*;

	localparam int DIG_W  = 17;
	localparam int PROD_W = 2 * OP_W;

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_ACC} mstate_t;

	mstate_t                  state_q;
	logic [1:0]               dig_q;
	logic [OP_W-1:0]          amag_q;
	logic [3*DIG_W-1:0]       bmag_q;
	logic                     neg_q;
	logic                     shl_q;
	logic [PROD_W-1:0]        prod_q;
	logic [ACC_W-1:0]         acc_q;
	logic                     done_q;
	logic [OP_W+DIG_W-1:0]    part;
	logic [PROD_W-1:0]        part_sh;
	logic [ACC_W-1:0]         term;

	// one partial product per cycle
	always_comb begin
		part    = amag_q * bmag_q[DIG_W*dig_q +: DIG_W];
		part_sh = PROD_W'(part) << (DIG_W * dig_q);
		term    = ACC_W'(prod_q) << (shl_q ? DER_SHIFT : 0);
	end

	assign done = done_q;
	assign acc  = acc_q;

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			dig_q   <= 2'd0;
		end else begin
			done_q <= (state_q == M_ACC);
			unique case (state_q)
				M_IDLE: begin
					if (cmd.start) begin
						amag_q  <= cmd.a[OP_W-1] ? OP_W'(-cmd.a) : OP_W'(cmd.a);
						bmag_q  <= (3*DIG_W)'(cmd.b[OP_W-1] ? OP_W'(-cmd.b) : OP_W'(cmd.b));
						neg_q   <= cmd.a[OP_W-1] ^ cmd.b[OP_W-1];
						shl_q   <= cmd.shl;
						prod_q  <= '0;
						dig_q   <= 2'd0;
						if (cmd.clr)
							acc_q <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					prod_q <= prod_q + part_sh;
					dig_q  <= dig_q + 2'd1;
					if (dig_q == 2'd2)
						state_q <= M_ACC;
				end
				M_ACC: begin
					acc_q   <= neg_q ? acc_q - term : acc_q + term;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/heph_back.sv =====
// ----------------------------------------------------------------------------
// heph_back
// Carries out inserts and interpolations against the sorted node table
// ----------------------------------------------------------------------------
`include "hermite_ephemeris_table_assert.svh"

module heph_back #(
	parameter int TABLE_DEPTH = 64,
	parameter int COMPONENTS  = 3,
	parameter int FRAC_BITS   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  heph_pkg::req_t req,
	output logic           req_pop,
	output logic           res_valid,
	output heph_pkg::res_t res,
	input  logic           res_ready
);
	import heph_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int ROW_W  = VAL_W * (1 + 2 * COMPONENTS);

	typedef enum logic [4:0] {
		S_IDLE, S_IRD, S_ICMP, S_IDEC, S_ISH, S_IMOV,
		S_Q0, S_QL, S_QRD, S_QCMP, S_DIVI, S_DIV, S_SQ, S_CU, S_H,
		S_MST, S_MWT, S_OUT
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               pos_q;
	logic [CNT_W-1:0]               idx_q;
	val_t                           t_q;
	logic [ROW_W-1:0]               nrow_q;
	logic [ROW_W-1:0]               r0_q;
	logic [ROW_W-1:0]               r1_q;
	logic [VAL_W-1:0]               dt_q;
	logic [VAL_W:0]                 rem_q;
	logic [4:0]                     divc_q;
	logic [31:0]                    s_q;
	logic [31:0]                    s2_q;
	logic [31:0]                    s3_q;
	logic signed [H_W-1:0]          h00_q, h01_q, h10_q, h11_q;
	logic [VAL_W-1:0]               g0_q, g1_q;
	logic [2:0]                     grp_q;
	logic [1:0]                     term_q;
	logic [MAX_COMP-1:0][VAL_W-1:0] out_q;
	status_t                        status_q;

	logic                           we;
	logic [ADDR_W-1:0]              waddr;
	logic [ROW_W-1:0]               wdata;
	logic [ADDR_W-1:0]              raddr;
	logic [ROW_W-1:0]               rdata;
	logic [CNT_W-1:0]               lastn;
	logic [CNT_W-1:0]               idx_m1;
	val_t                           rtime;
	val_t                           t0;
	logic [VAL_W:0]                 rem2;
	logic [63:0]                    sq_prod;
	logic [63:0]                    cu_prod;
	logic signed [H_W-1:0]          s_e, s2_e, s3_e;
	logic [1:0]                     comp;
	mac_cmd_t                       mcmd;
	logic                           mdone;
	logic [ACC_W-1:0]               macc;
	logic [VAL_W-1:0]               msat;

	heph_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_rows (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	heph_mac #(.DER_SHIFT(32 - FRAC_BITS)) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (mcmd),
		.done  (mdone),
		.acc   (macc)
	);

	// shared combinational helpers
	always_comb begin
		lastn   = cnt_q - CNT_W'(1);
		idx_m1  = idx_q - CNT_W'(1);
		rtime   = $signed(rdata[VAL_W-1:0]);
		t0      = $signed(r0_q[VAL_W-1:0]);
		rem2    = {rem_q[VAL_W-1:0], 1'b0};
		sq_prod = s_q * s_q;
		cu_prod = s2_q * s_q;
		s_e     = $signed(H_W'(s_q));
		s2_e    = $signed(H_W'(s2_q));
		s3_e    = $signed(H_W'(s3_q));
		comp    = 2'(grp_q - 3'd2);
		msat    = sat48(macc);
	end

	// table port control
	always_comb begin
		we    = 1'b0;
		waddr = pos_q[ADDR_W-1:0];
		wdata = nrow_q;
		raddr = '0;
		unique case (state_q)
			S_IRD:  raddr = pos_q[ADDR_W-1:0];
			S_ICMP: we = (rtime == t_q);
			S_ISH: begin
				raddr = idx_m1[ADDR_W-1:0];
				we    = (idx_q == pos_q);
			end
			S_IMOV: begin
				we    = 1'b1;
				waddr = idx_q[ADDR_W-1:0];
				wdata = rdata;
			end
			S_Q0:   raddr = lastn[ADDR_W-1:0];
			S_QRD:  raddr = pos_q[ADDR_W-1:0];
			default: ;
		endcase
	end

	// blend term operands
	always_comb begin
		mcmd.start = (state_q == S_MST);
		mcmd.clr   = (term_q == 2'd0);
		mcmd.shl   = term_q[1];
		mcmd.a     = OP_W'(h10_q);
		mcmd.b     = $signed({1'b0, dt_q});
		if (grp_q == 3'd1) begin
			mcmd.a = OP_W'(h11_q);
		end else if (grp_q >= 3'd2) begin
			unique case (term_q)
				2'd0: begin
					mcmd.a = OP_W'(h00_q);
					mcmd.b = OP_W'($signed(r0_q[VAL_W*(1+int'(comp)) +: VAL_W]));
				end
				2'd1: begin
					mcmd.a = OP_W'(h01_q);
					mcmd.b = OP_W'($signed(r1_q[VAL_W*(1+int'(comp)) +: VAL_W]));
				end
				2'd2: begin
					mcmd.a = OP_W'($signed(g0_q));
					mcmd.b = OP_W'($signed(
						r0_q[VAL_W*(1+COMPONENTS+int'(comp)) +: VAL_W]));
				end
				default: begin
					mcmd.a = OP_W'($signed(g1_q));
					mcmd.b = OP_W'($signed(
						r1_q[VAL_W*(1+COMPONENTS+int'(comp)) +: VAL_W]));
				end
			endcase
		end
	end

	assign req_pop    = (state_q == S_IDLE) && req_valid;
	assign res_valid  = (state_q == S_OUT);
	assign res.status = status_q;
	assign res.vals   = out_q;

	// sequencer, payload and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						t_q      <= $signed(req.epoch);
						nrow_q[VAL_W-1:0] <= req.epoch;
						for (int c = 0; c < COMPONENTS; c++) begin
							nrow_q[VAL_W*(1+c) +: VAL_W]            <= req.pos[c];
							nrow_q[VAL_W*(1+COMPONENTS+c) +: VAL_W] <= req.rate[c];
						end
						out_q    <= '0;
						status_q <= ST_OK;
						pos_q    <= '0;
						if (req.kind == KIND_INSERT)
							state_q <= S_IRD;
						else if (cnt_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_OUT;
						end else
							state_q <= S_Q0;
					end
				end
				// find the sorted position
				S_IRD: state_q <= (pos_q == cnt_q) ? S_IDEC : S_ICMP;
				S_ICMP: begin
					if (rtime < t_q) begin
						pos_q   <= pos_q + CNT_W'(1);
						state_q <= S_IRD;
					end else if (rtime == t_q)
						state_q <= S_OUT;
					else
						state_q <= S_IDEC;
				end
				S_IDEC: begin
					if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
						status_q <= ST_FULL;
						state_q  <= S_OUT;
					end else begin
						idx_q   <= cnt_q;
						state_q <= S_ISH;
					end
				end
				// open a gap by moving rows up one at a time
				S_ISH: begin
					if (idx_q == pos_q) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_OUT;
					end else
						state_q <= S_IMOV;
				end
				S_IMOV: begin
					idx_q   <= idx_m1;
					state_q <= S_ISH;
				end
				// end nodes and range check
				S_Q0: begin
					r0_q    <= rdata;
					state_q <= S_QL;
				end
				S_QL: begin
					r1_q <= rdata;
					if (t_q == t0) begin
						for (int c = 0; c < COMPONENTS; c++)
							out_q[c] <= r0_q[VAL_W*(1+c) +: VAL_W];
						state_q <= S_OUT;
					end else if (t_q == rtime) begin
						for (int c = 0; c < COMPONENTS; c++)
							out_q[c] <= rdata[VAL_W*(1+c) +: VAL_W];
						state_q <= S_OUT;
					end else if (t_q < t0 || t_q > rtime) begin
						status_q <= ST_RANGE;
						state_q  <= S_OUT;
					end else begin
						pos_q   <= CNT_W'(1);
						state_q <= S_QRD;
					end
				end
				// bracket search
				S_QRD: state_q <= (pos_q < lastn) ? S_QCMP : S_DIVI;
				S_QCMP: begin
					if (rtime <= t_q) begin
						r0_q    <= rdata;
						pos_q   <= pos_q + CNT_W'(1);
						state_q <= S_QRD;
					end else begin
						r1_q    <= rdata;
						state_q <= S_DIVI;
					end
				end
				// blend fraction by restoring division
				S_DIVI: begin
					dt_q    <= r1_q[VAL_W-1:0] - r0_q[VAL_W-1:0];
					rem_q   <= {1'b0, VAL_W'(t_q - t0)};
					s_q     <= '0;
					divc_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem2 >= {1'b0, dt_q}) begin
						rem_q <= rem2 - {1'b0, dt_q};
						s_q   <= {s_q[30:0], 1'b1};
					end else begin
						rem_q <= rem2;
						s_q   <= {s_q[30:0], 1'b0};
					end
					divc_q <= divc_q + 5'd1;
					if (divc_q == 5'd31)
						state_q <= S_SQ;
				end
				S_SQ: begin
					s2_q    <= sq_prod[63:32];
					state_q <= S_CU;
				end
				S_CU: begin
					s3_q    <= cu_prod[63:32];
					state_q <= S_H;
				end
				// hermite basis weights
				S_H: begin
					h00_q   <= 2 * s3_e - 3 * s2_e + H_W'(64'sd4294967296);
					h01_q   <= 3 * s2_e - 2 * s3_e;
					h10_q   <= s3_e - 2 * s2_e + s_e;
					h11_q   <= s3_e - s2_e;
					grp_q   <= 3'd0;
					term_q  <= 2'd0;
					state_q <= S_MST;
				end
				S_MST: state_q <= S_MWT;
				S_MWT: begin
					if (mdone) begin
						if (grp_q == 3'd0) begin
							g0_q    <= msat;
							grp_q   <= 3'd1;
							state_q <= S_MST;
						end else if (grp_q == 3'd1) begin
							g1_q    <= msat;
							grp_q   <= 3'd2;
							state_q <= S_MST;
						end else if (term_q == 2'd3) begin
							out_q[comp] <= msat;
							term_q      <= 2'd0;
							grp_q       <= grp_q + 3'd1;
							state_q     <= (int'(comp) == COMPONENTS - 1) ? S_OUT : S_MST;
						end else begin
							term_q  <= term_q + 2'd1;
							state_q <= S_MST;
						end
					end
				end
				S_OUT: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HEPH_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH), "node count above depth")
	`HEPH_ASSERT_IMP(a_full_only, res_valid && status_q == ST_FULL,
		cnt_q == CNT_W'(TABLE_DEPTH), "full reported on a table with room")
	`HEPH_ASSERT_IMP(a_div_rem, state_q == S_DIV, rem_q < {1'b0, dt_q},
		"division remainder not below divisor")

endmodule

// ===== rtl/hermite_ephemeris_table.sv =====
// ----------------------------------------------------------------------------
// hermite_ephemeris_table
// Sorted node table with cubic Hermite interpolation, Q31.16 fixed point
// ----------------------------------------------------------------------------
// Items enter on the s_ group: tuser selects insert (0) or interpolate (1),
// tdata carries the time and the node state and rates. Every item yields
// one result on the m_ group: tuser holds the status, tdata the components.
// A two-entry queue takes items while the engine is busy or a result waits.
// Items are processed one at a time against a single table memory, one row
// per node, one read and one write port.
// Insert: rows are scanned in order for the sorted position, then each row at or
// above it is moved up one place to open a gap; an overwrite or a full table
// ends right after the scan. Interpolate on an empty table returns the empty
// status without reading the table; at an end node or out of range it ends
// after reading the two end nodes; inside, it runs a bracket scan, a restoring
// divide at one bit a cycle and 2 + 4*COMPONENTS multiply terms, 17 bits a cycle.
// Results are held until m_tready; a stalled receiver backs up into the
// queue and then drops s_tready.
// Reset empties the table and the queue; no memory clearing pass is run.
// ----------------------------------------------------------------------------
module hermite_ephemeris_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int COMPONENTS  = 3,
	parameter int FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [335:0] s_tdata,   // epoch, pos_x, pos_y, pos_z, rate_x, rate_y, rate_z
	input  logic [0:0]   s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // out_x, out_y, out_z
	output logic [1:0]   m_tuser    // status
);
	import heph_pkg::*;

	logic req_valid;
	req_t req;
	logic req_pop;
	res_t res;

	heph_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.req_valid(req_valid),
		.req      (req),
		.req_pop  (req_pop)
	);

	heph_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COMPONENTS (COMPONENTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_pop  (req_pop),
		.res_valid(m_tvalid),
		.res      (res),
		.res_ready(m_tready)
	);

	// result packing, component 0 lowest
	always_comb begin
		m_tuser = res.status;
		for (int c = 0; c < MAX_COMP; c++)
			m_tdata[VAL_W*c +: VAL_W] = res.vals[c];
	end

endmodule

// ===== dv/hermite_ephemeris_table_tb.sv =====
// ----------------------------------------------------------------------------
// hermite_ephemeris_table_tb
// Self-checking bench for the sorted node table and its Hermite interpolation
// ----------------------------------------------------------------------------
// Items go in on the s_ stream with random gaps and come back on the m_ stream
// under random backpressure. A shadow copy of the node table predicts every
// status and every interpolated component, and a monitor compares each result
// with the oldest prediction. The table only grows, so the run builds it up,
// then fills it to the brim and keeps querying and overwriting.
// ----------------------------------------------------------------------------
module hermite_ephemeris_table_tb;
	import heph_pkg::*;

	localparam int DEPTH      = 64;
	localparam int NCOMP      = 3;
	localparam int FRAC       = 16;
	localparam int CYCLE_CAP  = 4000000;
	localparam int DRAIN_WAIT = 400;

	localparam val_t V_MAX = {1'b0, {47{1'b1}}};
	localparam val_t V_MIN = {1'b1, {47{1'b0}}};

	typedef struct {
		kind_t kind;
		val_t  epoch;
		val_t  pos [NCOMP];
		val_t  rate [NCOMP];
	} node_req_t;

	typedef struct {
		status_t status;
		val_t    vals [NCOMP];
	} state_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [335:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;

	// shadow node table
	val_t tbl_time [DEPTH];
	val_t tbl_pos  [DEPTH][NCOMP];
	val_t tbl_rate [DEPTH][NCOMP];
	int   tbl_count;

	state_res_t expected_states [$];
	int  mismatches;
	int  results_seen;
	int  items_sent;
	int  full_seen;
	int  cycles;
	bit  idle_on;
	int  hold_cycles;

	hermite_ephemeris_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stalls: random bursts, plus one long hold-off on request
	always @(posedge clk) begin : ready_gen
		int burst;
		if (!arst_n) begin
			m_tready <= 1'b0;
			burst = 0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (burst > 0) begin
			burst = burst - 1;
		end else begin
			burst = $urandom_range(0, 15);
			m_tready <= !(idle_on && $urandom_range(0, 2) == 0);
		end
	end

	// saturate an arithmetic right shift by 32 to 48 bits
	function automatic val_t clamp48(input logic signed [127:0] acc);
		logic signed [127:0] y;
		y = acc >>> 32;
		if (y > 128'(signed'(V_MAX)))
			return V_MAX;
		if (y < 128'(signed'(V_MIN)))
			return V_MIN;
		return y[47:0];
	endfunction

	// sorted insert or overwrite
	task automatic insert_node(input node_req_t rq, output status_t st);
		int at;
		at = 0;
		st = ST_OK;
		while (at < tbl_count && tbl_time[at] < rq.epoch)
			at++;
		if (!(at < tbl_count && tbl_time[at] == rq.epoch)) begin
			if (tbl_count >= DEPTH) begin
				st = ST_FULL;
				return;
			end
			for (int i = tbl_count; i > at; i--) begin
				tbl_time[i] = tbl_time[i-1];
				tbl_pos[i]  = tbl_pos[i-1];
				tbl_rate[i] = tbl_rate[i-1];
			end
			tbl_count++;
		end
		tbl_time[at] = rq.epoch;
		tbl_pos[at]  = rq.pos;
		tbl_rate[at] = rq.rate;
	endtask

	// hermite blend between the bracketing nodes
	task automatic interpolate_state(input val_t t, output state_res_t rs);
		int last, hi, k;
		logic [63:0] dt, rem, s, s2, s3;
		logic signed [63:0] h00, h01, h10, h11;
		logic signed [127:0] g0, g1, acc, der;
		rs.status = ST_OK;
		for (int c = 0; c < NCOMP; c++)
			rs.vals[c] = '0;
		if (tbl_count == 0) begin
			rs.status = ST_EMPTY;
			return;
		end
		last = tbl_count - 1;
		if (t == tbl_time[0] || t == tbl_time[last]) begin
			k = (t == tbl_time[0]) ? 0 : last;
			rs.vals = tbl_pos[k];
			return;
		end
		if (t < tbl_time[0] || t > tbl_time[last]) begin
			rs.status = ST_RANGE;
			return;
		end
		hi = 1;
		while (hi < last && tbl_time[hi] <= t)
			hi++;
		dt  = 64'(longint'(tbl_time[hi]) - longint'(tbl_time[hi-1]));
		rem = 64'(longint'(t) - longint'(tbl_time[hi-1]));
		s   = 0;
		for (int b = 0; b < 32; b++) begin
			rem = rem << 1;
			s   = s << 1;
			if (rem >= dt) begin
				rem  = rem - dt;
				s[0] = 1'b1;
			end
		end
		s2  = (s * s) >> 32;
		s3  = (s2 * s) >> 32;
		h00 = 2 * signed'(s3) - 3 * signed'(s2) + 64'sh1_0000_0000;
		h01 = 3 * signed'(s2) - 2 * signed'(s3);
		h10 = signed'(s3) - 2 * signed'(s2) + signed'(s);
		h11 = signed'(s3) - signed'(s2);
		g0  = 128'(signed'(clamp48(128'(h10) * 128'(signed'(dt)))));
		g1  = 128'(signed'(clamp48(128'(h11) * 128'(signed'(dt)))));
		for (int c = 0; c < NCOMP; c++) begin
			acc = 128'(h00) * 128'(tbl_pos[hi-1][c]) + 128'(h01) * 128'(tbl_pos[hi][c]);
			der = g0 * 128'(tbl_rate[hi-1][c]) + g1 * 128'(tbl_rate[hi][c]);
			acc = acc + (der <<< (32 - FRAC));
			rs.vals[c] = clamp48(acc);
		end
	endtask

	// send one item, predict its result once it is taken
	task automatic send_item(input node_req_t rq);
		state_res_t rs;
		status_t    st;
		s_tuser  <= rq.kind;
		s_tdata  <= {rq.rate[2], rq.rate[1], rq.rate[0], rq.pos[2], rq.pos[1], rq.pos[0],
			rq.epoch};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (rq.kind == KIND_INSERT) begin
			insert_node(rq, st);
			rs.status = st;
			for (int c = 0; c < NCOMP; c++)
				rs.vals[c] = '0;
			if (st == ST_FULL)
				full_seen++;
		end else begin
			interpolate_state(rq.epoch, rs);
		end
		expected_states.push_back(rs);
		items_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin : result_check
		state_res_t ex;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_states.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d data %h", m_tuser, m_tdata);
			end else begin
				ex = expected_states.pop_front();
				if (m_tuser != ex.status || m_tdata != {ex.vals[2], ex.vals[1], ex.vals[0]}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected status %0d data %h, got %0d %h",
							results_seen, ex.status, {ex.vals[2], ex.vals[1], ex.vals[0]},
							m_tuser, m_tdata);
				end
			end
		end
	end

	function automatic val_t rand48();
		return val_t'({$urandom, $urandom});
	endfunction

	// node values: full range, small, or an extreme
	function automatic val_t rand_value();
		case ($urandom_range(0, 5))
			0: return V_MAX;
			1: return V_MIN;
			2, 3: return rand48() >>> 24;
			default: return rand48();
		endcase
	endfunction

	function automatic node_req_t make_node(input val_t t);
		node_req_t rq;
		rq.kind  = KIND_INSERT;
		rq.epoch = t;
		for (int c = 0; c < NCOMP; c++) begin
			rq.pos[c]  = rand_value();
			rq.rate[c] = rand_value();
		end
		return rq;
	endfunction

	function automatic node_req_t make_query(input val_t t);
		node_req_t rq;
		rq = make_node(t);
		rq.kind = KIND_QUERY;
		return rq;
	endfunction

	// query time: on a node, inside a bracket, just outside, or anywhere
	function automatic val_t pick_query_time();
		int k;
		logic [63:0] span;
		if (tbl_count < 2)
			return rand48() >>> 8;
		k = $urandom_range(0, tbl_count - 2);
		case ($urandom_range(0, 9))
			0: return tbl_time[k];
			1: return tbl_time[0] - 1;
			2: return tbl_time[tbl_count-1] + 1;
			3: return tbl_time[tbl_count-1];
			4: return rand48();
			default: begin
				span = 64'(longint'(tbl_time[k+1]) - longint'(tbl_time[k]));
				return val_t'(longint'(tbl_time[k]) + longint'({$urandom, $urandom} % span));
			end
		endcase
	endfunction

	// one random item: mostly queries, an insert with insert_pct percent chance
	task automatic send_random(input int insert_pct);
		val_t t;
		if (tbl_count > 0 && $urandom_range(0, 99) < 20)
			t = tbl_time[$urandom_range(0, tbl_count - 1)];
		else
			t = rand48() >>> 8;
		if ($urandom_range(0, 99) < insert_pct)
			send_item(make_node(t));
		else
			send_item(make_query(pick_query_time()));
	endtask

	task automatic test_empty_table();
		send_item(make_query(V_MIN));
		send_item(make_query(V_MAX));
		send_item(make_query('0));
	endtask

	task automatic test_end_nodes();
		node_req_t rq;
		rq = make_node('0);
		rq.pos  = '{V_MAX, V_MIN, '0};
		rq.rate = '{V_MIN, V_MAX, V_MAX};
		send_item(rq);
		send_item(make_query('0));
		send_item(make_query(1));
		send_item(make_query(-1));
		rq = make_node(48'sh10_0000);
		rq.pos  = '{V_MIN, V_MAX, V_MIN};
		rq.rate = '{V_MAX, V_MIN, V_MIN};
		send_item(rq);
		send_item(make_query(48'sh10_0000));
		send_item(make_query(48'sh8_0000));
		send_item(make_query(48'sh1));
		send_item(make_query(48'shF_FFFF));
		// overwrite the first node
		send_item(make_node('0));
		send_item(make_query(48'sh4_0000));
		// new middle node, then queries at and beside it and just past the last node
		send_item(make_node(48'sh8_0000));
		send_item(make_query(48'sh8_0000));
		send_item(make_query(48'sh7_FFFF));
		send_item(make_query(48'sh8_0001));
		send_item(make_query(48'sh10_0001));
	endtask

	task automatic test_table_growth();
		for (int i = 0; i < 300; i++)
			send_random(tbl_count < 50 ? 35 : 10);
	endtask

	task automatic test_backpressure();
		hold_cycles <= 500;
		for (int i = 0; i < 12; i++)
			send_random(30);
	endtask

	task automatic test_full_table();
		val_t t;
		while (tbl_count < DEPTH - 2) begin
			t = rand48() >>> 8;
			send_item(make_node(t));
		end
		send_item(make_node(V_MIN));
		send_item(make_node(V_MAX));
		send_item(make_node(48'sh1234_5678));
		send_item(make_node(tbl_time[5]));
		send_item(make_query(V_MIN));
		send_item(make_query(V_MAX));
		send_item(make_query(V_MIN + 1));
		send_item(make_query(V_MAX - 1));
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 1330; i++) begin
			if (i == 1180)
				idle_on = 1'b0;
			send_random(25);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		cycles      = 0;
		mismatches  = 0;
		results_seen = 0;
		items_sent  = 0;
		full_seen   = 0;
		hold_cycles = 0;
		tbl_count   = 0;
		idle_on     = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_end_nodes();
		test_table_growth();
		test_backpressure();
		test_full_table();
		test_random_mix();
		s_tvalid <= 1'b0;

		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d items sent, %0d results checked, table at %0d nodes", items_sent,
			results_seen, tbl_count);
		$display("inserts rejected on a full table: %0d", full_seen);
		if (mismatches == 0 && expected_states.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/heph_pkg.sv
rtl/heph_ram.sv
rtl/heph_front.sv
rtl/heph_mac.sv
rtl/heph_back.sv
rtl/hermite_ephemeris_table.sv
dv/hermite_ephemeris_table_tb.sv
